@@ sv/svpwm_pkg.sv @@
// shared constants, codes and beat types for the svpwm compare-time block
package svpwm_pkg;

   localparam int SEC_W        = 3;
   localparam int NUM_W        = 35;
   localparam int PROD_W       = 50;
   localparam int DVD_W        = PROD_W - 16;
   localparam int T_W          = DVD_W;
   localparam int S_W          = T_W + 1;
   localparam int RSC_W        = T_W + 17;
   localparam int DIV_STAGES   = DVD_W;
   localparam int RSC_STAGES   = 16;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   localparam logic signed [NUM_W-1:0] K_SQRT3        = NUM_W'(113512);
   localparam logic signed [NUM_W-1:0] K_HALF_SQRT3   = NUM_W'(56756);
   localparam logic signed [NUM_W-1:0] K_THREE_HALVES = NUM_W'(98304);

   localparam logic [15:0] PERIOD_RESET = 16'd20000;
   localparam logic [15:0] DC_BUS_RESET = 16'd2560;

   typedef enum logic {
      REG_PERIOD = 1'b0,
      REG_DC_BUS = 1'b1
   } reg_idx_type;

   typedef enum logic [SEC_W-1:0] {
      SEC_NONE = 3'd0,
      SEC_1    = 3'd1,
      SEC_2    = 3'd2,
      SEC_3    = 3'd3,
      SEC_4    = 3'd4,
      SEC_5    = 3'd5,
      SEC_6    = 3'd6,
      SEC_ALL  = 3'd7
   } sector_type;

   typedef struct packed {
      sector_type                 sec;
      logic signed [PROD_W-1:0]   px;
      logic signed [PROD_W-1:0]   py;
      logic signed [PROD_W-1:0]   pz;
   } term_type;

   typedef struct packed {
      logic       full;
      logic       empty;
   } fifo_status_type;

   typedef struct packed {
      logic [15:0]      rem;
      logic [DVD_W-1:0] dq;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      sector_type   sec;
      div_lane_type lx;
      div_lane_type ly;
      div_lane_type lz;
   } div_stage_type;

   typedef struct packed {
      sector_type     sec;
      logic [T_W-1:0] t1;
      logic [T_W-1:0] t2;
   } act_type;

   typedef struct packed {
      sector_type       sec;
      logic             over;
      logic [S_W-1:0]   s;
      logic [15:0]      t1lo;
      logic [15:0]      t2lo;
      logic [RSC_W-1:0] r1;
      logic [RSC_W-1:0] r2;
      logic [15:0]      q1;
      logic [15:0]      q2;
   } rsc_type;

   typedef struct packed {
      logic [15:0] ca;
      logic [15:0] cb;
      logic [15:0] cc;
      sector_type  sec;
      logic        over;
   } result_type;

endpackage

@@ sv/svpwm_ifs.sv @@
// valid/ready channel interfaces for voltage requests and compare responses
interface svpwm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] u_alpha;
   logic signed [15:0] u_beta;

   modport source (output valid, output u_alpha, output u_beta, input ready);
   modport sink   (input valid, input u_alpha, input u_beta, output ready);
endinterface

interface svpwm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] compare_a;
   logic [15:0] compare_b;
   logic [15:0] compare_c;
   logic [2:0]  sector;
   logic        overmodulated;

   modport source (output valid, output compare_a, output compare_b, output compare_c,
                   output sector, output overmodulated, input ready);
   modport sink   (input valid, input compare_a, input compare_b, input compare_c,
                   input sector, input overmodulated, output ready);
endinterface

@@ sv/svpwm_front.sv @@
// front end: accepts request beats, finds the sector and forms the scaled terms
module svpwm_front (
   input  logic                      clock,
   input  logic                      reset,
   svpwm_req_if.sink                 req,
   input  logic [15:0]               period,
   input  svpwm_pkg::fifo_status_type status,
   output logic                      push,
   output svpwm_pkg::term_type       push_data
);
   import svpwm_pkg::*;

   typedef struct packed {
      sector_type               sec;
      logic signed [NUM_W-1:0]  nx;
      logic signed [NUM_W-1:0]  ny;
      logic signed [NUM_W-1:0]  nz;
   } num_type;

   logic                      en;
   logic                      f1_v_ff;
   logic                      f2_v_ff;
   num_type                   f1_ff;
   num_type                   f1_in;
   term_type                  f2_ff;
   term_type                  f2_in;
   logic signed [NUM_W-1:0]   a_ext;
   logic signed [NUM_W-1:0]   b_ext;
   logic signed [NUM_W-1:0]   a_sq;
   logic signed [NUM_W-1:0]   b_16;
   logic signed [NUM_W-1:0]   r2;
   logic signed [NUM_W-1:0]   r3;
   logic signed [PROD_W-1:0]  p_ext;

   assign en        = !f2_v_ff || !status.full;
   assign req.ready = en;
   assign push      = f2_v_ff && !status.full;
   assign push_data = f2_ff;

   always_comb begin
      a_ext = NUM_W'(req.u_alpha);
      b_ext = NUM_W'(req.u_beta);
      a_sq  = a_ext * K_SQRT3;
      b_16  = b_ext <<< 16;
      r2    = a_sq - b_16;
      r3    = -a_sq - b_16;
      f1_in.sec = sector_type'({r3 > 0, r2 > 0, req.u_beta > 16'sd0});
      f1_in.nx  = b_ext * K_SQRT3;
      f1_in.ny  = a_ext * K_THREE_HALVES + b_ext * K_HALF_SQRT3;
      f1_in.nz  = -(a_ext * K_THREE_HALVES) + b_ext * K_HALF_SQRT3;
   end

   always_comb begin
      p_ext     = PROD_W'($signed({1'b0, period}));
      f2_in.sec = f1_ff.sec;
      f2_in.px  = PROD_W'(f1_ff.nx) * p_ext;
      f2_in.py  = PROD_W'(f1_ff.ny) * p_ext;
      f2_in.pz  = PROD_W'(f1_ff.nz) * p_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= req.valid;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

endmodule

@@ sv/svpwm_fifo.sv @@
// short queue that decouples the front end from the divider pipeline
module svpwm_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  svpwm_pkg::term_type        push_data,
   input  logic                       pop,
   output svpwm_pkg::term_type        pop_data,
   output svpwm_pkg::fifo_status_type status
);
   import svpwm_pkg::*;

   term_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]       wr_ptr_ff;
   logic [FIFO_AW-1:0]       rd_ptr_ff;
   logic [FIFO_CW-1:0]       count_ff;
   logic [FIFO_CW-1:0]       count_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.full  = count_ff == FIFO_CW'(FIFO_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/svpwm_back.sv @@
// back end: divider pipeline, active-time selection, rescale and compare values
module svpwm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                period,
   input  logic [15:0]                dc_bus,
   input  svpwm_pkg::fifo_status_type status,
   input  svpwm_pkg::term_type        pop_data,
   output logic                       pop,
   svpwm_rsp_if.source                rsp
);
   import svpwm_pkg::*;

   function automatic div_lane_type lane_init(input logic signed [PROD_W-1:0] prod,
                                              input logic [15:0] dc);
      div_lane_type      l;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] bias;
      l.neg = prod[PROD_W-1];
      mag   = l.neg ? $unsigned(-prod) : $unsigned(prod);
      bias  = PROD_W'(dc) << 15;
      mag   = mag + bias;
      l.dq  = mag[PROD_W-1:16];
      l.rem = '0;
      return l;
   endfunction

   function automatic div_lane_type lane_step(input div_lane_type l, input logic [15:0] dc);
      div_lane_type n;
      logic [16:0]  t;
      logic [16:0]  diff;
      logic         ge;
      t     = {l.rem, l.dq[DVD_W-1]};
      diff  = t - {1'b0, dc};
      ge    = t >= {1'b0, dc};
      n.rem = ge ? diff[15:0] : t[15:0];
      n.dq  = {l.dq[DVD_W-2:0], ge};
      n.neg = l.neg;
      return n;
   endfunction

   function automatic logic [T_W-1:0] pos_part(input div_lane_type l);
      return l.neg ? '0 : l.dq;
   endfunction

   function automatic logic [T_W-1:0] neg_part(input div_lane_type l);
      return l.neg ? l.dq : '0;
   endfunction

   logic                 en;
   logic [15:0]          dc_eff;
   div_stage_type        div_ff [DIV_STAGES+1];
   div_stage_type        div_in [DIV_STAGES+1];
   logic [DIV_STAGES:0]  dv_ff;
   act_type              sel_ff;
   act_type              sel_in;
   logic                 sv_ff;
   rsc_type              rsc_ff [RSC_STAGES+1];
   rsc_type              rsc_in [RSC_STAGES+1];
   logic [RSC_STAGES:0]  rv_ff;
   result_type           out_ff;
   result_type           out_in;
   logic                 ov_ff;
   logic [15:0]          t1f;
   logic [15:0]          t2f;
   logic [16:0]          sf;
   logic [17:0]          ta4;
   logic [17:0]          tb4;
   logic [17:0]          tc4;
   logic [17:0]          ra;
   logic [17:0]          rb;
   logic [17:0]          rc;
   logic [RSC_W-1:0]     sd;
   logic                 ge1;
   logic                 ge2;

   assign en     = !ov_ff || rsp.ready;
   assign pop    = en && !status.empty;
   assign dc_eff = (dc_bus == '0) ? 16'd1 : dc_bus;

   always_comb begin
      div_in[0].sec = pop_data.sec;
      div_in[0].lx  = lane_init(pop_data.px, dc_eff);
      div_in[0].ly  = lane_init(pop_data.py, dc_eff);
      div_in[0].lz  = lane_init(pop_data.pz, dc_eff);
      for (int k = 1; k <= DIV_STAGES; k++) begin
         div_in[k].sec = div_ff[k-1].sec;
         div_in[k].lx  = lane_step(div_ff[k-1].lx, dc_eff);
         div_in[k].ly  = lane_step(div_ff[k-1].ly, dc_eff);
         div_in[k].lz  = lane_step(div_ff[k-1].lz, dc_eff);
      end
   end

   always_comb begin
      sel_in.sec = div_ff[DIV_STAGES].sec;
      unique case (div_ff[DIV_STAGES].sec)
         SEC_1: begin
            sel_in.t1 = pos_part(div_ff[DIV_STAGES].lz);
            sel_in.t2 = pos_part(div_ff[DIV_STAGES].ly);
         end
         SEC_2: begin
            sel_in.t1 = pos_part(div_ff[DIV_STAGES].ly);
            sel_in.t2 = neg_part(div_ff[DIV_STAGES].lx);
         end
         SEC_3: begin
            sel_in.t1 = neg_part(div_ff[DIV_STAGES].lz);
            sel_in.t2 = pos_part(div_ff[DIV_STAGES].lx);
         end
         SEC_4: begin
            sel_in.t1 = neg_part(div_ff[DIV_STAGES].lx);
            sel_in.t2 = pos_part(div_ff[DIV_STAGES].lz);
         end
         SEC_5: begin
            sel_in.t1 = pos_part(div_ff[DIV_STAGES].lx);
            sel_in.t2 = neg_part(div_ff[DIV_STAGES].ly);
         end
         SEC_6: begin
            sel_in.t1 = neg_part(div_ff[DIV_STAGES].ly);
            sel_in.t2 = neg_part(div_ff[DIV_STAGES].lz);
         end
         default: begin
            sel_in.t1 = '0;
            sel_in.t2 = '0;
         end
      endcase
   end

   always_comb begin
      rsc_in[0].sec  = sel_ff.sec;
      rsc_in[0].s    = S_W'(sel_ff.t1) + S_W'(sel_ff.t2);
      rsc_in[0].over = rsc_in[0].s > S_W'(period);
      rsc_in[0].t1lo = sel_ff.t1[15:0];
      rsc_in[0].t2lo = sel_ff.t2[15:0];
      rsc_in[0].r1   = RSC_W'(sel_ff.t1) * RSC_W'(period);
      rsc_in[0].r2   = RSC_W'(sel_ff.t2) * RSC_W'(period);
      rsc_in[0].q1   = '0;
      rsc_in[0].q2   = '0;
      sd  = '0;
      ge1 = 1'b0;
      ge2 = 1'b0;
      for (int i = 1; i <= RSC_STAGES; i++) begin
         sd  = RSC_W'(rsc_ff[i-1].s) << (RSC_STAGES - i);
         ge1 = rsc_ff[i-1].r1 >= sd;
         ge2 = rsc_ff[i-1].r2 >= sd;
         rsc_in[i]    = rsc_ff[i-1];
         rsc_in[i].r1 = ge1 ? rsc_ff[i-1].r1 - sd : rsc_ff[i-1].r1;
         rsc_in[i].r2 = ge2 ? rsc_ff[i-1].r2 - sd : rsc_ff[i-1].r2;
         rsc_in[i].q1 = {rsc_ff[i-1].q1[14:0], ge1};
         rsc_in[i].q2 = {rsc_ff[i-1].q2[14:0], ge2};
      end
   end

   always_comb begin
      t1f = rsc_ff[RSC_STAGES].over ? rsc_ff[RSC_STAGES].q1 : rsc_ff[RSC_STAGES].t1lo;
      t2f = rsc_ff[RSC_STAGES].over ? rsc_ff[RSC_STAGES].q2 : rsc_ff[RSC_STAGES].t2lo;
      sf  = 17'(t1f) + 17'(t2f);
      ta4 = 18'(period) - 18'(sf);
      tb4 = ta4 + (18'(t1f) << 1);
      tc4 = tb4 + (18'(t2f) << 1);
      ra  = ta4 + 18'd2;
      rb  = tb4 + 18'd2;
      rc  = tc4 + 18'd2;
      out_in.sec  = rsc_ff[RSC_STAGES].sec;
      out_in.over = rsc_ff[RSC_STAGES].over;
      unique case (rsc_ff[RSC_STAGES].sec)
         SEC_1: begin
            out_in.ca = rb[17:2]; out_in.cb = ra[17:2]; out_in.cc = rc[17:2];
         end
         SEC_2: begin
            out_in.ca = ra[17:2]; out_in.cb = rc[17:2]; out_in.cc = rb[17:2];
         end
         SEC_3: begin
            out_in.ca = ra[17:2]; out_in.cb = rb[17:2]; out_in.cc = rc[17:2];
         end
         SEC_4: begin
            out_in.ca = rc[17:2]; out_in.cb = rb[17:2]; out_in.cc = ra[17:2];
         end
         SEC_5: begin
            out_in.ca = rc[17:2]; out_in.cb = ra[17:2]; out_in.cc = rb[17:2];
         end
         SEC_6: begin
            out_in.ca = rb[17:2]; out_in.cb = rc[17:2]; out_in.cc = ra[17:2];
         end
         default: begin
            out_in.ca = ra[17:2]; out_in.cb = ra[17:2]; out_in.cc = ra[17:2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         sv_ff <= 1'b0;
         rv_ff <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= {dv_ff[DIV_STAGES-1:0], !status.empty};
         sv_ff <= dv_ff[DIV_STAGES];
         rv_ff <= {rv_ff[RSC_STAGES-1:0], sv_ff};
         ov_ff <= rv_ff[RSC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
         sel_ff <= sel_in;
         rsc_ff <= rsc_in;
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = ov_ff;
   assign rsp.compare_a     = out_ff.ca;
   assign rsp.compare_b     = out_ff.cb;
   assign rsp.compare_c     = out_ff.cc;
   assign rsp.sector        = out_ff.sec;
   assign rsp.overmodulated = out_ff.over;

endmodule

@@ sv/svpwm_compare_times_core.sv @@
// top level of the seven-segment space-vector compare-time calculator
//
// req_chan carries one voltage beat (u_alpha, u_beta, signed q8.8) per
// valid/ready handshake; rsp_chan returns exactly one beat per request with
// the three phase compare values in ticks, the sector code and the
// overmodulation flag, in request order.
// throughput: one beat per cycle while rsp_chan.ready stays high.
// from request acceptance to the response beat the path runs through two
// front stages, one queue slot, one operand stage, a 34-stage radix-2
// divider by the bus voltage, selection, sum/multiply, a 16-stage rescale
// divider and the output register.
// when the receiver stalls the back pipeline holds, the 4-beat queue fills
// and then req_chan.ready drops; the response beat stays stable until taken.
// period_ticks (address 0) and dc_bus_voltage (address 4) are to be written
// over the csr_ apb port only while empty; the block does not enforce it.
// writes take effect at once. synchronous reset empties the pipeline and
// queue and loads a period of 20000 ticks and a bus voltage of 10 V.
module svpwm_compare_times_core (
   input  logic                              clock,
   input  logic                              reset,
   svpwm_req_if.sink                         req_chan,
   svpwm_rsp_if.source                       rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [svpwm_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [svpwm_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [svpwm_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                              csr_pready
);
   import svpwm_pkg::*;

   logic [15:0]      period_ff;
   logic [15:0]      dc_bus_ff;
   logic             csr_wr;
   reg_idx_type      csr_idx;
   logic             push;
   logic             pop;
   term_type         push_data;
   term_type         pop_data;
   fifo_status_type  status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_idx)
         REG_PERIOD: csr_prdata = CSR_DW'(period_ff);
         REG_DC_BUS: csr_prdata = CSR_DW'(dc_bus_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         dc_bus_ff <= DC_BUS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PERIOD: period_ff <= csr_pwdata[15:0];
            REG_DC_BUS: dc_bus_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   svpwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .period    (period_ff),
      .status    (status),
      .push      (push),
      .push_data (push_data)
   );

   svpwm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   svpwm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .period   (period_ff),
      .dc_bus   (dc_bus_ff),
      .status   (status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

@@ sv/svpwm_checker.sv @@
// port-level checks on the response channel, bound to the top level
module svpwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] compare_a,
   input logic [15:0] compare_b,
   input logic [15:0] compare_c,
   input logic [2:0]  sector,
   input logic        overmodulated
);
   import svpwm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(compare_a) && $stable(compare_b)
         && $stable(compare_c) && $stable(sector) && $stable(overmodulated))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_sector_all: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> sector != SEC_ALL)
      else $error("impossible sector code");

   a_half_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> compare_a <= 16'd32768 && compare_b <= 16'd32768
         && compare_c <= 16'd32768)
      else $error("compare value above half the largest period");

   a_null_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sector == SEC_NONE |-> !overmodulated
         && compare_a == compare_b && compare_b == compare_c)
      else $error("null sector with active times");

endmodule

bind svpwm_compare_times_core svpwm_checker u_svpwm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .compare_a     (rsp_chan.compare_a),
   .compare_b     (rsp_chan.compare_b),
   .compare_c     (rsp_chan.compare_c),
   .sector        (rsp_chan.sector),
   .overmodulated (rsp_chan.overmodulated)
);

@@ sim/tb.sv @@
// testbench for svpwm_compare_times_core: directed and random voltage beats against a predictor
`timescale 1ns / 100ps

module tb;
   import svpwm_pkg::*;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   svpwm_req_if req_if ();
   svpwm_rsp_if rsp_if ();

   svpwm_compare_times_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if.sink),
      .rsp_chan    (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [15:0] cfg_period;
   logic [15:0] cfg_dc_bus;
   result_type  compare_q[$];
   int          err_count;
   bit          no_gaps;
   bit          sink_free;

   initial begin
      clock = 1'b0;
   end
   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic result_type predict_compare(logic signed [15:0] ua, logic signed [15:0] ub);
      result_type res;
      longint a, b, p, den, r2, r3, x, y, z, t1, t2, s, ta, tb, tc;
      sector_type sec;
      logic [2:0] code;
      bit over;
      a = ua;
      b = ub;
      p = cfg_period;
      den = ((cfg_dc_bus == 16'd0) ? 64'd1 : longint'(cfg_dc_bus)) * 65536;
      r2 = a * 113512 - b * 65536;
      r3 = -a * 113512 - b * 65536;
      code = {r3 > 0, r2 > 0, b > 0};
      sec = sector_type'(code);
      x = round_div(b * 113512 * p, den);
      y = round_div((a * 98304 + b * 56756) * p, den);
      z = round_div((-a * 98304 + b * 56756) * p, den);
      case (sec)
         SEC_1: begin t1 = z;  t2 = y;  end
         SEC_2: begin t1 = y;  t2 = -x; end
         SEC_3: begin t1 = -z; t2 = x;  end
         SEC_4: begin t1 = -x; t2 = z;  end
         SEC_5: begin t1 = x;  t2 = -y; end
         SEC_6: begin t1 = -y; t2 = -z; end
         default: begin t1 = 0; t2 = 0; end
      endcase
      if (t1 < 0) t1 = 0;
      if (t2 < 0) t2 = 0;
      s = t1 + t2;
      over = 1'b0;
      if (s > p) begin
         over = 1'b1;
         t1 = (t1 * p) / s;
         t2 = (t2 * p) / s;
         s = t1 + t2;
      end
      ta = p - s;
      tb = ta + 2 * t1;
      tc = tb + 2 * t2;
      ta = (ta + 2) >>> 2;
      tb = (tb + 2) >>> 2;
      tc = (tc + 2) >>> 2;
      case (sec)
         SEC_1: begin res.ca = 16'(tb); res.cb = 16'(ta); res.cc = 16'(tc); end
         SEC_2: begin res.ca = 16'(ta); res.cb = 16'(tc); res.cc = 16'(tb); end
         SEC_3: begin res.ca = 16'(ta); res.cb = 16'(tb); res.cc = 16'(tc); end
         SEC_4: begin res.ca = 16'(tc); res.cb = 16'(tb); res.cc = 16'(ta); end
         SEC_5: begin res.ca = 16'(tc); res.cb = 16'(ta); res.cc = 16'(tb); end
         SEC_6: begin res.ca = 16'(tb); res.cb = 16'(tc); res.cc = 16'(ta); end
         default: begin res.ca = 16'(ta); res.cb = 16'(ta); res.cc = 16'(ta); end
      endcase
      res.sec = sec;
      res.over = over;
      return res;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_voltage(logic signed [15:0] ua, logic signed [15:0] ub);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.u_alpha = ua;
      req_if.u_beta = ub;
      do @(posedge clock); while (!req_if.ready);
      compare_q.push_back(predict_compare(ua, ub));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (compare_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [15:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = {16'h0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== value)
         $error("readback reg %0d: expected %0d actual %0d", idx, value, csr_prdata[15:0]);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (idx == REG_PERIOD) cfg_period = value;
      else cfg_dc_bus = value;
   endtask

   task automatic set_config(logic [15:0] period, logic [15:0] dc_bus);
      wait_drained();
      write_reg(REG_PERIOD, period);
      write_reg(REG_DC_BUS, dc_bus);
   endtask

   task automatic send_random(int count);
      logic signed [15:0] ua, ub;
      int lim;
      repeat (count) begin
         lim = (cfg_dc_bus > 16'd8) ? int'(cfg_dc_bus) : 8;
         if (lim > 32767) lim = 32767;
         case ($urandom_range(0, 3))
            0: begin ua = 16'($urandom); ub = 16'($urandom); end
            1: begin
               ua = 16'(int'($urandom_range(0, 32)) - 16);
               ub = 16'(int'($urandom_range(0, 32)) - 16);
            end
            default: begin
               ua = 16'(int'($urandom_range(0, 2 * lim)) - lim);
               ub = 16'(int'($urandom_range(0, 2 * lim)) - lim);
            end
         endcase
         send_voltage(ua, ub);
      end
   endtask

   task automatic test_directed();
      send_voltage(16'sd0, 16'sd0);
      send_voltage(-16'sd32768, -16'sd32768);
      send_voltage(16'sd32767, 16'sd32767);
      send_voltage(16'sd32767, -16'sd32768);
      send_voltage(-16'sd32768, 16'sd32767);
      send_voltage(16'sd1000, 16'sd300);
      send_voltage(16'sd300, 16'sd1000);
      send_voltage(-16'sd300, 16'sd1000);
      send_voltage(-16'sd1000, 16'sd300);
      send_voltage(-16'sd1000, -16'sd300);
      send_voltage(-16'sd300, -16'sd1000);
      send_voltage(16'sd300, -16'sd1000);
      send_voltage(16'sd1000, -16'sd300);
      send_voltage(16'sd1000, 16'sd0);
      send_voltage(-16'sd1000, 16'sd0);
      send_voltage(16'sd0, -16'sd1000);
      send_voltage(16'sd0, 16'sd1000);
      send_voltage(16'sd1, -16'sd1);
      send_voltage(16'sd2000, 16'sd1200);
      send_voltage(-16'sd5000, 16'sd4000);
   endtask

   task automatic test_config_extremes();
      set_config(16'd65535, 16'd1);
      send_random(20);
      set_config(16'd1, 16'd65535);
      send_random(20);
      // zero period and zero bus voltage
      set_config(16'd0, 16'd0);
      send_random(20);
      set_config(16'd0, 16'd2560);
      send_random(10);
   endtask

   task automatic test_random();
      set_config(16'd20000, 16'd2560);
      send_random(150);
      no_gaps = 1'b1;
      sink_free = 1'b1;
      send_random(60);
      no_gaps = 1'b0;
      sink_free = 1'b0;
      set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      send_random(120);
      set_config(16'($urandom_range(100, 4000)), 16'($urandom_range(256, 8192)));
      send_random(120);
      set_config(16'd65535, 16'd65535);
      send_random(60);
   endtask

   task automatic test_pressure();
      set_config(16'd32768, 16'd512);
      send_random(30);
      wait_drained();
      no_gaps = 1'b1;
      send_random(30);
      no_gaps = 1'b0;
   endtask

   initial begin
      int hold;
      int r;
      rsp_if.ready = 1'b0;
      hold = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            r = $urandom_range(0, 99);
            if (sink_free || r < 55) begin
               rsp_if.ready = 1'b1;
               hold = $urandom_range(1, 8);
            end else if (r < 90) begin
               rsp_if.ready = 1'b0;
               hold = $urandom_range(1, 3);
            end else begin
               rsp_if.ready = 1'b0;
               hold = $urandom_range(15, 60);
            end
         end
         hold--;
      end
   end

   always @(posedge clock) begin
      result_type exp_res;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (compare_q.size() == 0) begin
            $error("response beat with nothing expected");
            err_count++;
         end else begin
            exp_res = compare_q.pop_front();
            if (rsp_if.compare_a !== exp_res.ca) begin
               $error("compare_a: expected %0d actual %0d", exp_res.ca, rsp_if.compare_a);
               err_count++;
            end
            if (rsp_if.compare_b !== exp_res.cb) begin
               $error("compare_b: expected %0d actual %0d", exp_res.cb, rsp_if.compare_b);
               err_count++;
            end
            if (rsp_if.compare_c !== exp_res.cc) begin
               $error("compare_c: expected %0d actual %0d", exp_res.cc, rsp_if.compare_c);
               err_count++;
            end
            if (rsp_if.sector !== exp_res.sec) begin
               $error("sector: expected %0d actual %0d", exp_res.sec, rsp_if.sector);
               err_count++;
            end
            if (rsp_if.overmodulated !== exp_res.over) begin
               $error("overmodulated: expected %0d actual %0d", exp_res.over,
                      rsp_if.overmodulated);
               err_count++;
            end
         end
      end
   end

   initial begin
      err_count = 0;
      no_gaps = 1'b0;
      sink_free = 1'b0;
      cfg_period = PERIOD_RESET;
      cfg_dc_bus = DC_BUS_RESET;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.u_alpha = '0;
      req_if.u_beta = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_config_extremes();
      test_random();
      test_pressure();
      wait_drained();
      repeat (20) @(negedge clock);
      if (err_count == 0 && compare_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
